>>> rtl/pcg_pkg.sv
`default_nettype none

package pcg_pkg;

    // field widths fixed by the interface
    localparam int SUBJ_FIELD_W = 32;
    localparam int BYTES_W      = 17;
    localparam int QCOUNT_OUT_W = 16;
    localparam int SBITS_W      = 6;
    localparam int COST_OUT_W   = 21;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam int SUBJECT_LEN_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF       = 16;
    localparam int QUEUE_DEPTH_DEF      = 4;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [7:0] CHAR_ESCAPE    = 8'h25;  // '%'
    localparam logic [7:0] CHAR_SET_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CHAR_CARET     = 8'h5E;  // '^'
    localparam logic [7:0] CHAR_SET_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CHAR_STAR      = 8'h2A;  // '*'
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;  // '-'

    localparam logic [1:0] REG_MAX_SUBJECT = 2'd0;
    localparam logic [1:0] REG_MAX_PATTERN = 2'd1;
    localparam logic [1:0] REG_MAX_COST    = 2'd2;

    localparam logic [31:0] MAX_SUBJECT_RST = 32'd65536;
    localparam logic [15:0] MAX_PATTERN_RST = 16'd1024;
    localparam logic [20:0] MAX_COST_RST    = 21'd24;

    typedef enum logic [1:0] {
        VERDICT_OK           = 2'd0,
        VERDICT_SUBJECT_LONG = 2'd1,
        VERDICT_PATTERN_LONG = 2'd2,
        VERDICT_TOO_COMPLEX  = 2'd3
    } verdict_t;

    typedef struct packed {
        logic                    command;
        logic [7:0]              pattern_char;
        logic [SUBJ_FIELD_W-1:0] subj_length;
    } pcg_in_t;

    typedef struct packed {
        verdict_t                verdict;
        logic [QCOUNT_OUT_W-1:0] quantifier_count;
        logic [SBITS_W-1:0]      subject_bits;
        logic [COST_OUT_W-1:0]   cost_value;
    } pcg_out_t;

    typedef struct packed {
        logic [31:0] max_subject_len;
        logic [15:0] max_pattern_len;
        logic [20:0] max_cost_bits;
    } pcg_cfg_t;

endpackage

`default_nettype wire

>>> rtl/pattern_cost_guard_core.sv
`default_nettype none

// Admission check for a backtracking pattern matcher. Pattern bytes arrive one
// per input word (command 0) and an end word (command 1) carries the subject
// length; each end word yields one result word with the verdict and counts,
// and clears the parse state. Input words are taken one per cycle while the
// queue has room: the parser state in the front end is registered. End words
// enter a small queue and each one then passes the bit-length stage, the
// multiply stage and the output register; the back end sustains one result
// per cycle unless m_ready stalls it. Registers on the APB port: 0x0
// max_subject_len, 0x4 max_pattern_len, 0x8 max_cost_bits; write them only
// while no end word is in flight.
module pattern_cost_guard_core #(
    parameter int SUBJECT_LEN_BITS = pcg_pkg::SUBJECT_LEN_BITS_DEF,
    parameter int COUNT_BITS       = pcg_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH      = pcg_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire pcg_pkg::pcg_in_t            s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output pcg_pkg::pcg_out_t                m_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pcg_pkg::PADDR_W-1:0] paddr,
    input  wire logic [pcg_pkg::PDATA_W-1:0] pwdata,
    output logic [pcg_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    localparam int SUBJ_W = (SUBJECT_LEN_BITS < pcg_pkg::SUBJ_FIELD_W) ?
                            SUBJECT_LEN_BITS : pcg_pkg::SUBJ_FIELD_W;
    localparam int JOB_W  = SUBJ_W + pcg_pkg::BYTES_W + COUNT_BITS;

    pcg_pkg::pcg_cfg_t              cfg_reg;
    logic                           cfg_wr;
    logic [1:0]                     reg_idx;

    logic                           q_push, q_pop, q_full, q_empty;
    logic [SUBJ_W-1:0]              f_subj, b_subj;
    logic [pcg_pkg::BYTES_W-1:0]    f_bytes, b_bytes;
    logic [COUNT_BITS-1:0]          f_quant, b_quant;
    logic [JOB_W-1:0]               q_in, q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_subject_len <= pcg_pkg::MAX_SUBJECT_RST;
            cfg_reg.max_pattern_len <= pcg_pkg::MAX_PATTERN_RST;
            cfg_reg.max_cost_bits   <= pcg_pkg::MAX_COST_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                pcg_pkg::REG_MAX_SUBJECT: cfg_reg.max_subject_len <= pwdata;
                pcg_pkg::REG_MAX_PATTERN: cfg_reg.max_pattern_len <= pwdata[15:0];
                pcg_pkg::REG_MAX_COST:    cfg_reg.max_cost_bits   <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pcg_pkg::REG_MAX_SUBJECT: prdata = cfg_reg.max_subject_len;
            pcg_pkg::REG_MAX_PATTERN: prdata = pcg_pkg::PDATA_W'(cfg_reg.max_pattern_len);
            pcg_pkg::REG_MAX_COST:    prdata = pcg_pkg::PDATA_W'(cfg_reg.max_cost_bits);
            default:                  prdata = '0;
        endcase
    end

    pcg_front #(
        .SUBJECT_LEN_BITS (SUBJECT_LEN_BITS),
        .COUNT_BITS       (COUNT_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_subj  (f_subj),
        .q_bytes (f_bytes),
        .q_quant (f_quant)
    );

    assign q_in = {f_subj, f_bytes, f_quant};
    assign {b_subj, b_bytes, b_quant} = q_out;

    pcg_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    pcg_back #(
        .SUBJECT_LEN_BITS (SUBJECT_LEN_BITS),
        .COUNT_BITS       (COUNT_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_subj  (b_subj),
        .q_bytes (b_bytes),
        .q_quant (b_quant),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> rtl/pcg_front.sv
`default_nettype none

module pcg_front #(
    parameter int SUBJECT_LEN_BITS = pcg_pkg::SUBJECT_LEN_BITS_DEF,
    parameter int COUNT_BITS       = pcg_pkg::COUNT_BITS_DEF,
    localparam int SUBJ_W = (SUBJECT_LEN_BITS < pcg_pkg::SUBJ_FIELD_W) ?
                            SUBJECT_LEN_BITS : pcg_pkg::SUBJ_FIELD_W
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire pcg_pkg::pcg_in_t            s_data,
    input  wire logic                        q_full,
    output logic                             q_push,
    output logic [SUBJ_W-1:0]                q_subj,
    output logic [pcg_pkg::BYTES_W-1:0]      q_bytes,
    output logic [COUNT_BITS-1:0]            q_quant
);

    typedef enum logic [3:0] {
        MODE_OUT   = 4'b0001,
        MODE_OPEN  = 4'b0010,
        MODE_CARET = 4'b0100,
        MODE_SET   = 4'b1000
    } mode_t;

    mode_t                          mode_reg, mode_next;
    logic                           esc_reg, esc_next;
    logic [pcg_pkg::BYTES_W-1:0]    bytes_reg, bytes_next;
    logic [COUNT_BITS-1:0]          quant_reg, quant_next;
    logic                           accept;
    logic [7:0]                     c;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.pattern_char;

    assign q_push  = accept && (s_data.command == pcg_pkg::CMD_END);
    assign q_subj  = s_data.subj_length[SUBJ_W-1:0];
    assign q_bytes = bytes_reg;
    assign q_quant = quant_reg;

    always_comb begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        bytes_next = bytes_reg;
        quant_next = quant_reg;
        if (accept) begin
            if (s_data.command == pcg_pkg::CMD_END) begin
                mode_next  = MODE_OUT;
                esc_next   = 1'b0;
                bytes_next = '0;
                quant_next = '0;
            end else begin
                if (bytes_reg != '1) begin
                    bytes_next = bytes_reg + pcg_pkg::BYTES_W'(1);
                end
                priority if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (mode_reg == MODE_OPEN && c == pcg_pkg::CHAR_CARET) begin
                    mode_next = MODE_CARET;
                end else if ((mode_reg == MODE_OPEN || mode_reg == MODE_CARET) &&
                             c == pcg_pkg::CHAR_SET_CLOSE) begin
                    // ']' right after the opening is a literal member
                    mode_next = MODE_SET;
                end else if (c == pcg_pkg::CHAR_ESCAPE) begin
                    esc_next = 1'b1;
                    if (mode_reg != MODE_OUT) begin
                        mode_next = MODE_SET;
                    end
                end else if (mode_reg != MODE_OUT) begin
                    mode_next = (c == pcg_pkg::CHAR_SET_CLOSE) ? MODE_OUT : MODE_SET;
                end else if (c == pcg_pkg::CHAR_SET_OPEN) begin
                    mode_next = MODE_OPEN;
                end else if (c == pcg_pkg::CHAR_STAR || c == pcg_pkg::CHAR_PLUS ||
                             c == pcg_pkg::CHAR_MINUS) begin
                    if (quant_reg != '1) begin
                        quant_next = quant_reg + COUNT_BITS'(1);
                    end
                end else begin
                    mode_next = mode_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_OUT;
            esc_reg   <= 1'b0;
            bytes_reg <= '0;
            quant_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            bytes_reg <= bytes_next;
            quant_reg <= quant_next;
        end
    end

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> (bytes_reg == '0) && (quant_reg == '0) && !esc_reg &&
                   (mode_reg == MODE_OUT))
        else $error("parse state not cleared after end word");

endmodule

`default_nettype wire

>>> rtl/pcg_queue.sv
`default_nettype none

module pcg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pcg_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("queue pop while empty");

endmodule

`default_nettype wire

>>> rtl/pcg_back.sv
`default_nettype none

module pcg_back #(
    parameter int SUBJECT_LEN_BITS = pcg_pkg::SUBJECT_LEN_BITS_DEF,
    parameter int COUNT_BITS       = pcg_pkg::COUNT_BITS_DEF,
    localparam int SUBJ_W = (SUBJECT_LEN_BITS < pcg_pkg::SUBJ_FIELD_W) ?
                            SUBJECT_LEN_BITS : pcg_pkg::SUBJ_FIELD_W
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pcg_pkg::pcg_cfg_t           cfg,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    input  wire logic [SUBJ_W-1:0]           q_subj,
    input  wire logic [pcg_pkg::BYTES_W-1:0] q_bytes,
    input  wire logic [COUNT_BITS-1:0]       q_quant,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output pcg_pkg::pcg_out_t                m_data
);

    localparam int COST_W = COUNT_BITS + pcg_pkg::SBITS_W;
    localparam int CMP_W  = (COST_W > pcg_pkg::COST_OUT_W) ? COST_W : pcg_pkg::COST_OUT_W;
    localparam int QX_W   = (COUNT_BITS > pcg_pkg::QCOUNT_OUT_W) ?
                            COUNT_BITS : pcg_pkg::QCOUNT_OUT_W;

    // stage 1: bit length of subject length
    logic                           st1_valid_reg;
    logic [SUBJ_W-1:0]              st1_subj_reg;
    logic [pcg_pkg::BYTES_W-1:0]    st1_bytes_reg;
    logic [COUNT_BITS-1:0]          st1_quant_reg;
    logic [pcg_pkg::SBITS_W-1:0]    st1_bits_reg;
    // stage 2: cost product
    logic                           st2_valid_reg;
    logic [SUBJ_W-1:0]              st2_subj_reg;
    logic [pcg_pkg::BYTES_W-1:0]    st2_bytes_reg;
    logic [COUNT_BITS-1:0]          st2_quant_reg;
    logic [pcg_pkg::SBITS_W-1:0]    st2_bits_reg;
    logic [COST_W-1:0]              st2_cost_reg;
    // output register
    logic                           m_valid_reg;
    pcg_pkg::pcg_out_t              m_data_reg, m_data_next;

    logic                           out_free, st2_free, st1_free;
    logic [pcg_pkg::SBITS_W-1:0]    bits_len;
    logic [CMP_W-1:0]               cost_x;
    logic [QX_W-1:0]                quant_x;
    logic                           subj_over, bytes_over, cost_over;

    assign out_free = !m_valid_reg || m_ready;
    assign st2_free = !st2_valid_reg || out_free;
    assign st1_free = !st1_valid_reg || st2_free;
    assign q_pop    = !q_empty && st1_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // leading-one position + 1
    always_comb begin
        bits_len = '0;
        for (int i = 0; i < SUBJ_W; i++) begin
            if (q_subj[i]) begin
                bits_len = pcg_pkg::SBITS_W'(i + 1);
            end
        end
    end

    assign cost_x  = CMP_W'(st2_cost_reg);
    assign quant_x = QX_W'(st2_quant_reg);

    assign subj_over  = pcg_pkg::SUBJ_FIELD_W'(st2_subj_reg) > cfg.max_subject_len;
    assign bytes_over = st2_bytes_reg > pcg_pkg::BYTES_W'(cfg.max_pattern_len);
    assign cost_over  = cost_x > CMP_W'(cfg.max_cost_bits);

    always_comb begin
        priority if (subj_over) begin
            m_data_next.verdict = pcg_pkg::VERDICT_SUBJECT_LONG;
        end else if (bytes_over) begin
            m_data_next.verdict = pcg_pkg::VERDICT_PATTERN_LONG;
        end else if (cost_over) begin
            m_data_next.verdict = pcg_pkg::VERDICT_TOO_COMPLEX;
        end else begin
            m_data_next.verdict = pcg_pkg::VERDICT_OK;
        end
        m_data_next.quantifier_count =
            (quant_x > QX_W'({pcg_pkg::QCOUNT_OUT_W{1'b1}})) ?
            {pcg_pkg::QCOUNT_OUT_W{1'b1}} : quant_x[pcg_pkg::QCOUNT_OUT_W-1:0];
        m_data_next.subject_bits = st2_bits_reg;
        m_data_next.cost_value =
            (cost_x > CMP_W'({pcg_pkg::COST_OUT_W{1'b1}})) ?
            {pcg_pkg::COST_OUT_W{1'b1}} : cost_x[pcg_pkg::COST_OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (st1_free) begin
                st1_valid_reg <= !q_empty;
            end
            if (st2_free) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= st2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_free) begin
            st1_subj_reg  <= q_subj;
            st1_bytes_reg <= q_bytes;
            st1_quant_reg <= q_quant;
            st1_bits_reg  <= bits_len;
        end
        if (st2_free) begin
            st2_subj_reg  <= st1_subj_reg;
            st2_bytes_reg <= st1_bytes_reg;
            st2_quant_reg <= st1_quant_reg;
            st2_bits_reg  <= st1_bits_reg;
            st2_cost_reg  <= COST_W'(st1_quant_reg) * COST_W'(st1_bits_reg);
        end
        if (out_free) begin
            m_data_reg <= m_data_next;
        end
    end

    a_out_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !st2_valid_reg |=> !m_valid)
        else $error("result word repeated");

    a_st2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        st2_valid_reg && !out_free |=> st2_valid_reg && $stable(st2_cost_reg))
        else $error("cost stage lost while output stalled");

endmodule

`default_nettype wire

>>> bench/tb_pattern_cost_guard_core.sv
`timescale 1ns / 100ps

module tb_pattern_cost_guard_core;

    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 6;
    localparam int PHASE_WORDS     = 270;
    localparam int DIR_PATTERN_LIM = 16;

    typedef enum logic [3:0] {
        SET_NONE   = 4'b0001,
        SET_OPENED = 4'b0010,
        SET_CARET  = 4'b0100,
        SET_BODY   = 4'b1000
    } set_state_t;

    typedef struct {
        pcg_pkg::pcg_in_t  word;
        int                reps;
        bit                typed;
        pcg_pkg::pcg_out_t res;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pcg_pkg::pcg_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pcg_pkg::pcg_out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pcg_pkg::PADDR_W-1:0] paddr = '0;
    logic [pcg_pkg::PDATA_W-1:0] pwdata = '0;
    logic [pcg_pkg::PDATA_W-1:0] prdata;
    logic pready;

    // predictor state and its copy of the limits
    set_state_t  set_st = SET_NONE;
    bit          esc_pending = 1'b0;
    logic [16:0] pat_bytes = '0;
    logic [15:0] quant_cnt = '0;
    logic [31:0] lim_subject = pcg_pkg::MAX_SUBJECT_RST;
    logic [15:0] lim_pattern = pcg_pkg::MAX_PATTERN_RST;
    logic [20:0] lim_cost = pcg_pkg::MAX_COST_RST;

    pcg_pkg::pcg_out_t verdict_q[$];
    dir_row_t          dir_rows[$];
    int                mismatch_cnt = 0;
    int                burst_left = 0;
    bit                hold_req = 1'b0;
    pcg_pkg::pcg_out_t exp_w;

    pattern_cost_guard_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Parser and verdict for one accepted word.
    function automatic void judge_word(input pcg_pkg::pcg_in_t w, output bit has,
                                       output pcg_pkg::pcg_out_t res);
        logic [7:0]        c;
        logic [5:0]        nb;
        int unsigned       cost;
        pcg_pkg::verdict_t v;
        c = w.pattern_char;
        has = 1'b0;
        res = '0;
        if (w.command == pcg_pkg::CMD_BYTE) begin
            if (pat_bytes != 17'h1FFFF)
                pat_bytes++;
            if (esc_pending) begin
                esc_pending = 1'b0;
            end else if (set_st == SET_OPENED && c == pcg_pkg::CHAR_CARET) begin
                set_st = SET_CARET;
            end else if ((set_st == SET_OPENED || set_st == SET_CARET) &&
                         c == pcg_pkg::CHAR_SET_CLOSE) begin
                set_st = SET_BODY;  // literal ']' right after the opening
            end else if (c == pcg_pkg::CHAR_ESCAPE) begin
                esc_pending = 1'b1;
                if (set_st != SET_NONE)
                    set_st = SET_BODY;
            end else if (set_st != SET_NONE) begin
                set_st = (c == pcg_pkg::CHAR_SET_CLOSE) ? SET_NONE : SET_BODY;
            end else if (c == pcg_pkg::CHAR_SET_OPEN) begin
                set_st = SET_OPENED;
            end else if (c == pcg_pkg::CHAR_STAR || c == pcg_pkg::CHAR_PLUS ||
                         c == pcg_pkg::CHAR_MINUS) begin
                if (quant_cnt != 16'hFFFF)
                    quant_cnt++;
            end
        end else begin
            nb = '0;
            for (int i = 0; i < 32; i++)
                if (w.subj_length[i])
                    nb = 6'(i + 1);
            cost = quant_cnt * nb;
            if (w.subj_length > lim_subject)
                v = pcg_pkg::VERDICT_SUBJECT_LONG;
            else if (pat_bytes > {1'b0, lim_pattern})
                v = pcg_pkg::VERDICT_PATTERN_LONG;
            else if (cost > lim_cost)
                v = pcg_pkg::VERDICT_TOO_COMPLEX;
            else
                v = pcg_pkg::VERDICT_OK;
            res.verdict = v;
            res.quantifier_count = quant_cnt;
            res.subject_bits = nb;
            res.cost_value = cost[20:0];
            has = 1'b1;
            set_st = SET_NONE;
            esc_pending = 1'b0;
            pat_bytes = '0;
            quant_cnt = '0;
        end
    endfunction

    function automatic void add_row(input logic cmd, input logic [7:0] ch,
                                    input logic [31:0] subj, input int reps,
                                    input bit typed, input pcg_pkg::pcg_out_t res);
        dir_row_t row;
        row.word = {cmd, ch, subj};
        row.reps = reps;
        row.typed = typed;
        row.res = res;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row(pcg_pkg::CMD_BYTE, s[i], 32'h0, 1, 1'b0, '0);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    task automatic put_word(input pcg_pkg::pcg_in_t w, input bit typed,
                            input pcg_pkg::pcg_out_t typed_res);
        int                gap;
        bit                has;
        pcg_pkg::pcg_out_t pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        judge_word(w, has, pred);
        if (has)
            verdict_q.push_back(typed ? typed_res : pred);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pcg_pkg::REG_MAX_SUBJECT: lim_subject = val;
            pcg_pkg::REG_MAX_PATTERN: lim_pattern = val[15:0];
            pcg_pkg::REG_MAX_COST:    lim_cost = val[20:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // byte words leave no result, so allow the pipeline to settle as well
    task automatic drain();
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : rx_pattern
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(10, 150);
                end
                left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result word: v=%0d q=%0d b=%0d c=%0d",
                             m_data.verdict, m_data.quantifier_count,
                             m_data.subject_bits, m_data.cost_value);
            end else begin
                exp_w = verdict_q.pop_front();
                if (m_data.verdict !== exp_w.verdict
                        || m_data.quantifier_count !== exp_w.quantifier_count
                        || m_data.subject_bits !== exp_w.subject_bits
                        || m_data.cost_value !== exp_w.cost_value) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result mismatch: exp v=%0d q=%0d b=%0d c=%0d,",
                                 exp_w.verdict, exp_w.quantifier_count,
                                 exp_w.subject_bits, exp_w.cost_value,
                                 " got v=%0d q=%0d b=%0d c=%0d",
                                 m_data.verdict, m_data.quantifier_count,
                                 m_data.subject_bits, m_data.cost_value);
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int          len;
        logic [7:0]  ch;
        logic [31:0] subj;
        logic [31:0] cfg_subj;
        logic [31:0] cfg_pat;
        logic [31:0] cfg_cost;
        int          n;

        // directed part, subject and cost limits at reset, pattern limit lowered
        add_row(pcg_pkg::CMD_END, 8'h00, 32'h0, 1, 1'b1,
                {pcg_pkg::VERDICT_OK, 16'd0, 6'd0, 21'd0});
        add_row(pcg_pkg::CMD_END, 8'hFF, 32'hFFFF_FFFF, 1, 1'b1,
                {pcg_pkg::VERDICT_SUBJECT_LONG, 16'd0, 6'd32, 21'd0});
        add_text("***+-");
        add_row(pcg_pkg::CMD_END, 8'h00, 32'd65536, 1, 1'b1,
                {pcg_pkg::VERDICT_TOO_COMPLEX, 16'd5, 6'd17, 21'd85});
        add_text("%*%%+");
        // subject field ignored here
        add_row(pcg_pkg::CMD_BYTE, "a", 32'hDEAD_BEEF, 1, 1'b0, '0);
        add_row(pcg_pkg::CMD_END, 8'h00, 32'd1, 1, 1'b0, '0);
        // sets with caret, literal close, escape inside, then an unclosed set
        add_text("[^]*]*[]%]-][%*");
        add_row(pcg_pkg::CMD_END, 8'h00, 32'd3, 1, 1'b0, '0);
        add_text("*");
        add_row(pcg_pkg::CMD_END, 8'h00, 32'd0, 1, 1'b0, '0);
        add_row(pcg_pkg::CMD_BYTE, "a", 32'h0, DIR_PATTERN_LIM, 1'b0, '0);
        add_row(pcg_pkg::CMD_END, 8'h00, 32'd10, 1, 1'b0, '0);
        add_row(pcg_pkg::CMD_BYTE, "a", 32'h0, DIR_PATTERN_LIM + 1, 1'b0, '0);
        add_row(pcg_pkg::CMD_END, 8'h00, 32'd10, 1, 1'b1,
                {pcg_pkg::VERDICT_PATTERN_LONG, 16'd0, 6'd4, 21'd0});
        add_row(pcg_pkg::CMD_BYTE, pcg_pkg::CHAR_STAR, 32'h0, DIR_PATTERN_LIM + 1,
                1'b0, '0);
        add_row(pcg_pkg::CMD_END, 8'h00, 32'd65537, 1, 1'b1,
                {pcg_pkg::VERDICT_SUBJECT_LONG, 16'd17, 6'd17, 21'd289});

        while (!aresetn) @(posedge aclk);
        cfg_write(pcg_pkg::REG_MAX_SUBJECT, pcg_pkg::MAX_SUBJECT_RST);
        cfg_write(pcg_pkg::REG_MAX_PATTERN, 32'(DIR_PATTERN_LIM));
        cfg_write(pcg_pkg::REG_MAX_COST, 32'(pcg_pkg::MAX_COST_RST));

        foreach (dir_rows[k])
            for (int r = 0; r < dir_rows[k].reps; r++)
                put_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].res);

        for (int ph = 0; ph < PHASES; ph++) begin
            s_valid <= 1'b0;
            drain();
            case (ph)
                0: begin
                    cfg_subj = 32'hFFFF_FFFF;
                    cfg_pat = 32'd65535;
                    cfg_cost = 32'd2097120;
                end
                1: begin
                    cfg_subj = 32'd0;
                    cfg_pat = 32'd0;
                    cfg_cost = 32'd0;
                end
                default: begin
                    cfg_subj = $urandom >> $urandom_range(0, 31);
                    cfg_pat = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 48);
                    cfg_cost = $urandom_range(0, 300);
                end
            endcase
            cfg_write(pcg_pkg::REG_MAX_SUBJECT, cfg_subj);
            cfg_write(pcg_pkg::REG_MAX_PATTERN, cfg_pat);
            cfg_write(pcg_pkg::REG_MAX_COST, cfg_cost);
            if (ph == 2)
                hold_req = 1'b1;

            n = 0;
            while (n < PHASE_WORDS) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 12);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 11))
                        0:       ch = pcg_pkg::CHAR_ESCAPE;
                        1:       ch = pcg_pkg::CHAR_SET_OPEN;
                        2:       ch = pcg_pkg::CHAR_CARET;
                        3:       ch = pcg_pkg::CHAR_SET_CLOSE;
                        4:       ch = pcg_pkg::CHAR_STAR;
                        5:       ch = pcg_pkg::CHAR_PLUS;
                        6:       ch = pcg_pkg::CHAR_MINUS;
                        default: ch = 8'($urandom_range(0, 255));
                    endcase
                    put_word({pcg_pkg::CMD_BYTE, ch, 32'($urandom)}, 1'b0, '0);
                    n++;
                end
                case ($urandom_range(0, 7))
                    0:       subj = 32'h0;
                    1:       subj = 32'hFFFF_FFFF;
                    2:       subj = lim_subject + 32'($urandom_range(0, 2)) - 32'd1;
                    default: subj = $urandom >> $urandom_range(0, 32);
                endcase
                put_word({pcg_pkg::CMD_END, 8'($urandom_range(0, 255)), subj}, 1'b0, '0);
                n++;
            end
        end

        s_valid <= 1'b0;
        drain();
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
